>>> src/sd_spi_command_read_engine_unit_macros.svh
// Assertion macros for the SD SPI read engine.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef SD_SPI_COMMAND_READ_ENGINE_UNIT_MACROS_SVH
`define SD_SPI_COMMAND_READ_ENGINE_UNIT_MACROS_SVH
// implication checked on every edge outside reset
`define SDSPI_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// implication whose consequent is checked on the next cycle
`define SDSPI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`endif

>>> src/sdspi_pkg.sv
// Shared types and constants for the SD SPI read engine.
// No dependencies.
`timescale 1ns / 1ps
package sdspi_pkg;
	localparam logic [3:0] PH_IDLE = 4'd0, PH_LEAD = 4'd1, PH_FRAME = 4'd2, PH_R1POLL = 4'd3,
		PH_R2BYTE = 4'd4, PH_WORD = 4'd5, PH_TOKEN = 4'd6, PH_DATA = 4'd7, PH_CRC = 4'd8,
		PH_TRAIL = 4'd9;
	localparam logic [3:0] ST_OK = 4'd0, ST_RESP_TO = 4'd1, ST_ILLEGAL = 4'd2,
		ST_CMD_CRC = 4'd3, ST_ERASE = 4'd4, ST_ADDR = 4'd5, ST_PARAM = 4'd6,
		ST_TOKEN_TO = 4'd7, ST_ERR_TOK = 4'd8, ST_CC = 4'd9, ST_ECC = 4'd10,
		ST_RANGE = 4'd11, ST_DATA_CRC = 4'd12;
	localparam logic [2:0] RT_R2 = 3'd2, RT_R3 = 3'd3, RT_R7 = 3'd4;
	localparam logic [7:0] BYTE_IDLE = 8'hFF, TOKEN_START = 8'hFE, CMD_START = 8'h40;

	typedef struct packed {
		logic       op;
		logic [5:0] cmd_index;
		logic [31:0] cmd_arg;
		logic [2:0] resp_type;
		logic [15:0] block_count;
		logic [11:0] blk_bytes;
		logic [15:0] data_timeout;
		logic [7:0] rx_byte;
	} req_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       tx_valid;
		logic       cs_active;
		logic       data_valid;
		logic [7:0] data_byte;
		logic       done_res;
		logic [3:0] status;
		logic [7:0] r1;
		logic [7:0] r2;
		logic [31:0] resp_word;
	} res_t;

	function automatic logic [6:0] crc7_byte(input logic [6:0] crc, input logic [7:0] b);
		logic [6:0] c;
		logic fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[6] ^ b[i];
			c = {c[5:0], 1'b0};
			if (fb) c = c ^ 7'h09;
		end
		return c;
	endfunction

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) c = {c[14:0], 1'b0} ^ 16'h1021;
			else c = {c[14:0], 1'b0};
		end
		return c;
	endfunction
endpackage

>>> src/sdspi_core.sv
// Engine state and next-step logic for one byte exchange per item.
// Depends on sdspi_pkg and the assertion macros header; instantiated by the top level.
`timescale 1ns / 1ps
module sdspi_core #(
	parameter int MAX_BLOCK_LEN   = 2048,
	parameter int RESP_POLL_LIMIT = 30
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic            crc_en,
	input  sdspi_pkg::req_t req,
	output sdspi_pkg::res_t res
);
	import sdspi_pkg::*;
	`include "sd_spi_command_read_engine_unit_macros.svh"

	localparam logic [12:0] MAXL = 13'(MAX_BLOCK_LEN);
	localparam logic [7:0] POLLS = 8'(RESP_POLL_LIMIT);

	logic [3:0]  phase_q, phase_d;
	logic [12:0] bcnt_q, bcnt_d;
	logic [15:0] wcnt_q, wcnt_d;
	logic [15:0] blk_q, blk_d;
	logic [39:0] frame_q, frame_d;
	logic [6:0]  crc7_q, crc7_d;
	logic [15:0] c16_q, c16_d, crx_q, crx_d;
	logic [2:0]  rt_q, rt_d;
	logic [12:0] bl_q, bl_d;
	logic [15:0] to_q, to_d;
	logic [7:0]  r1_q, r1_d, r2_q, r2_d;
	logic [31:0] word_q, word_d;
	logic [3:0]  fst_q, fst_d;
	res_t        o;

	function automatic logic [7:0] fbyte(input logic [39:0] f, input logic [6:0] c,
		input logic [12:0] k);
		case (k)
			13'd0: return f[39:32];
			13'd1: return f[31:24];
			13'd2: return f[23:16];
			13'd3: return f[15:8];
			13'd4: return f[7:0];
			default: return {c, 1'b1};
		endcase
	endfunction

	function automatic logic [3:0] check_r1(input logic [7:0] r);
		if (r[2]) return ST_ILLEGAL;
		if (r[3]) return ST_CMD_CRC;
		if (r[4]) return ST_ERASE;
		if (r[5]) return ST_ADDR;
		if (r[6]) return ST_PARAM;
		return ST_OK;
	endfunction

	always_comb begin
		logic [12:0] bl;
		logic [39:0] fr;
		logic [6:0] c7;
		logic [3:0] st;
		logic aft;
		phase_d = phase_q; bcnt_d = bcnt_q; wcnt_d = wcnt_q; blk_d = blk_q;
		frame_d = frame_q; crc7_d = crc7_q; c16_d = c16_q; crx_d = crx_q;
		rt_d = rt_q; bl_d = bl_q; to_d = to_q; r1_d = r1_q; r2_d = r2_q;
		word_d = word_q; fst_d = fst_q;
		o = '0;
		aft = 1'b0;
		st = ST_OK;
		bl = {1'b0, req.blk_bytes};
		if (bl > MAXL) bl = MAXL;
		fr = {CMD_START | {2'b00, req.cmd_index}, req.cmd_arg};
		c7 = 7'd0;
		for (int k = 0; k < 5; k++) c7 = crc7_byte(c7, fr[39 - 8 * k -: 8]);
		if (!req.op) begin
			blk_d = req.block_count; rt_d = req.resp_type; bl_d = bl;
			to_d = req.data_timeout; frame_d = fr; crc7_d = c7;
			r1_d = BYTE_IDLE; r2_d = '0; word_d = '0; fst_d = ST_OK;
			bcnt_d = '0; wcnt_d = '0; c16_d = '0; crx_d = '0;
			phase_d = PH_LEAD;
			o.tx_byte = BYTE_IDLE; o.tx_valid = 1'b1; o.cs_active = 1'b1;
		end else begin
			case (phase_q)
				PH_LEAD: begin
					bcnt_d = '0; phase_d = PH_FRAME;
					o.tx_byte = fbyte(frame_q, crc7_q, 13'd0);
					o.tx_valid = 1'b1; o.cs_active = 1'b1;
				end
				PH_FRAME: begin
					o.tx_valid = 1'b1; o.cs_active = 1'b1;
					if (bcnt_q < 13'd5) begin
						bcnt_d = bcnt_q + 13'd1;
						o.tx_byte = fbyte(frame_q, crc7_q, bcnt_q + 13'd1);
					end else begin
						wcnt_d = {8'd0, POLLS}; phase_d = PH_R1POLL;
						o.tx_byte = BYTE_IDLE;
					end
				end
				PH_R1POLL: begin
					r1_d = req.rx_byte;
					if (req.rx_byte != BYTE_IDLE) begin
						if (req.rx_byte[3:2] == 2'b00 && rt_q == RT_R2) begin
							phase_d = PH_R2BYTE;
							o.tx_byte = BYTE_IDLE; o.tx_valid = 1'b1; o.cs_active = 1'b1;
						end else if (req.rx_byte[3:2] == 2'b00 &&
							(rt_q == RT_R3 || rt_q == RT_R7)) begin
							bcnt_d = '0; phase_d = PH_WORD;
							o.tx_byte = BYTE_IDLE; o.tx_valid = 1'b1; o.cs_active = 1'b1;
						end else aft = 1'b1;
					end else begin
						wcnt_d = {8'd0, wcnt_q[7:0] - 8'd1};
						if (wcnt_q[7:0] == 8'd1) begin
							fst_d = ST_RESP_TO; phase_d = PH_TRAIL;
							o.tx_byte = BYTE_IDLE; o.tx_valid = 1'b1;
						end else begin
							o.tx_byte = BYTE_IDLE; o.tx_valid = 1'b1; o.cs_active = 1'b1;
						end
					end
				end
				PH_R2BYTE: begin
					r2_d = req.rx_byte; aft = 1'b1;
				end
				PH_WORD: begin
					word_d = {word_q[23:0], req.rx_byte};
					bcnt_d = bcnt_q + 13'd1;
					if (bcnt_q + 13'd1 >= 13'd4) aft = 1'b1;
					else begin
						o.tx_byte = BYTE_IDLE; o.tx_valid = 1'b1; o.cs_active = 1'b1;
					end
				end
				PH_TOKEN: begin
					o.tx_byte = BYTE_IDLE; o.tx_valid = 1'b1; o.cs_active = 1'b1;
					if (req.rx_byte == TOKEN_START) begin
						bcnt_d = '0; c16_d = '0; crx_d = '0;
						phase_d = (bl_q == 13'd0) ? PH_CRC : PH_DATA;
					end else if (req.rx_byte[7:4] == 4'd0 && req.rx_byte != 8'd0) begin
						o.cs_active = 1'b0; phase_d = PH_TRAIL;
						if (req.rx_byte[0]) fst_d = ST_ERR_TOK;
						else if (req.rx_byte[1]) fst_d = ST_CC;
						else if (req.rx_byte[2]) fst_d = ST_ECC;
						else fst_d = ST_RANGE;
					end else begin
						wcnt_d = wcnt_q - 16'd1;
						if (wcnt_q == 16'd1) begin
							o.cs_active = 1'b0; phase_d = PH_TRAIL; fst_d = ST_TOKEN_TO;
						end
					end
				end
				PH_DATA: begin
					o.data_valid = 1'b1; o.data_byte = req.rx_byte;
					c16_d = crc16_byte(c16_q, req.rx_byte);
					bcnt_d = bcnt_q + 13'd1;
					if (bcnt_q + 13'd1 >= bl_q) begin
						bcnt_d = '0; phase_d = PH_CRC;
					end
					o.tx_byte = BYTE_IDLE; o.tx_valid = 1'b1; o.cs_active = 1'b1;
				end
				PH_CRC: begin
					crx_d = {crx_q[7:0], req.rx_byte};
					bcnt_d = bcnt_q + 13'd1;
					o.tx_byte = BYTE_IDLE; o.tx_valid = 1'b1; o.cs_active = 1'b1;
					if (bcnt_q + 13'd1 < 13'd2) begin
					end else if (crc_en && {crx_q[7:0], req.rx_byte} != c16_q) begin
						o.cs_active = 1'b0; phase_d = PH_TRAIL; fst_d = ST_DATA_CRC;
					end else begin
						blk_d = blk_q - 16'd1;
						if (blk_q == 16'd1) begin
							o.cs_active = 1'b0; phase_d = PH_TRAIL; fst_d = ST_OK;
						end else begin
							wcnt_d = to_q; phase_d = PH_TOKEN;
						end
					end
				end
				PH_TRAIL: begin
					o.done_res = 1'b1; phase_d = PH_IDLE;
					o.status = fst_q; o.r1 = r1_q; o.r2 = r2_q; o.resp_word = word_q;
				end
				default: phase_d = PH_IDLE;
			endcase
			if (aft) begin
				o.tx_byte = BYTE_IDLE; o.tx_valid = 1'b1;
				st = check_r1(r1_d);
				if (blk_q == 16'd0) begin
					fst_d = ST_OK; phase_d = PH_TRAIL;
				end else if (st != ST_OK) begin
					fst_d = st; phase_d = PH_TRAIL;
				end else begin
					wcnt_d = to_q; phase_d = PH_TOKEN; o.cs_active = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; bcnt_q <= '0; wcnt_q <= '0; blk_q <= '0; frame_q <= '0;
			crc7_q <= '0; c16_q <= '0; crx_q <= '0; rt_q <= '0; bl_q <= '0; to_q <= '0;
			r1_q <= '0; r2_q <= '0; word_q <= '0; fst_q <= '0;
		end else if (step) begin
			phase_q <= phase_d; bcnt_q <= bcnt_d; wcnt_q <= wcnt_d; blk_q <= blk_d;
			frame_q <= frame_d; crc7_q <= crc7_d; c16_q <= c16_d; crx_q <= crx_d;
			rt_q <= rt_d; bl_q <= bl_d; to_q <= to_d; r1_q <= r1_d; r2_q <= r2_d;
			word_q <= word_d; fst_q <= fst_d;
		end
	end

	assign res = o;

	`SDSPI_ASSERT_IMP(a_done_only_trail, step && o.done_res, phase_q == PH_TRAIL && req.op,
		"done outside trailing phase")
	`SDSPI_ASSERT_NEXT(a_start_leads, step && !req.op, phase_q == PH_LEAD,
		"start did not enter lead phase")
	`SDSPI_ASSERT_IMP(a_data_in_data, step && o.data_valid, phase_q == PH_DATA,
		"data byte outside data phase")
	`SDSPI_ASSERT_IMP(a_len_sat, 1'b1, bl_q <= MAXL, "block length above limit")
endmodule

>>> src/sd_spi_command_read_engine_unit.sv
// The result of an accepted item is registered in the output register as the item is taken.
// Throughput: one item per cycle while m_axis is ready; the output register is reloaded while it is being taken.
// Each item is one SPI byte exchange; the CRC7 of the frame is formed on the start item.
// Reset (arst_n low, asynchronous) returns the engine to idle and clears crc_en_q.
// Back-pressure on m_axis stalls s_axis; no item is dropped.
`timescale 1ns / 1ps
module sd_spi_command_read_engine_unit #(
	parameter int MAX_BLOCK_LEN   = 2048,
	parameter int RESP_POLL_LIMIT = 30
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// cmd_index[5:0], cmd_arg[37:6], resp_type[40:38], block_count[56:41],
	// blk_bytes[68:57], data_timeout[84:69], rx_byte[92:85], zero pad to 96
	input  logic [95:0]  s_axis_tdata,
	input  logic         s_axis_tuser,   // op
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tx_byte[7:0], tx_valid[8], cs_active[9], data_valid[10], data_byte[18:11],
	// done_res[19], status[23:20], r1[31:24], r2[39:32], resp_word[71:40]
	output logic [71:0]  m_axis_tdata
);
	import sdspi_pkg::*;

	logic crc_en_q;
	logic step;
	req_t req;
	res_t res;

	// config register; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) crc_en_q <= 1'b0;
		else if (cfg_we) crc_en_q <= cfg_wdata;
	end

	// a new item may enter whenever the output slot is empty or being emptied
	assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
	assign step = s_axis_tvalid && s_axis_tready;

	assign req.op           = s_axis_tuser;
	assign req.cmd_index    = s_axis_tdata[5:0];
	assign req.cmd_arg      = s_axis_tdata[37:6];
	assign req.resp_type    = s_axis_tdata[40:38];
	assign req.block_count  = s_axis_tdata[56:41];
	assign req.blk_bytes    = s_axis_tdata[68:57];
	assign req.data_timeout = s_axis_tdata[84:69];
	assign req.rx_byte      = s_axis_tdata[92:85];

	sdspi_core #(.MAX_BLOCK_LEN(MAX_BLOCK_LEN), .RESP_POLL_LIMIT(RESP_POLL_LIMIT)) u_core (
		.clk(clk), .arst_n(arst_n), .step(step), .crc_en(crc_en_q), .req(req), .res(res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (s_axis_tready) m_axis_tvalid <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (step)
			m_axis_tdata <= {res.resp_word, res.r2, res.r1, res.status, res.done_res,
				res.data_byte, res.data_valid, res.cs_active, res.tx_valid, res.tx_byte};
	end
endmodule
